FILE: rtl/core/rfo_pkg.sv
`default_nettype none

package rfo_pkg;

	localparam int WORD_W    = 32;
	localparam int OFFSET_W  = 4;
	localparam int RUN_W     = 5;
	localparam int HELD_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 3;

	typedef enum logic [2:0] {
		OP_PUT    = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_NEWEST = 3'd3,
		OP_RUN    = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_LOG2 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE  = 1'b1;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [WORD_W-1:0]   item_value;
		logic [OFFSET_W-1:0] slot_offset;
		logic [RUN_W-1:0]    run_length;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		logic              succeeded;
		logic              last_of_run;
		logic [HELD_W-1:0] items_held;
		logic              is_full;
		logic              is_empty;
	} result_t;

	// status carried alongside a RAM read to the output stage
	typedef struct packed {
		logic              ok;
		logic              has_word;
		logic              last;
		logic [HELD_W-1:0] held;
		logic              full;
		logic              empty;
	} beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rfo_ram.sv
`default_nettype none

module rfo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ring_fifo_with_overwrite_core.sv
`default_nettype none

// Single commands: one accepted per cycle when idle, result strobed on done via valid_s1.
// A read run of L words holds busy until its last read issues; the store's single
// read port delivers one word per cycle, so the L results arrive on consecutive cycles.
// Reset clears both pointers (ring empty), slots_log2 to 4 and overwrite off; store
// contents stay undefined. Results are strobed for one cycle and cannot be held off.
module ring_fifo_with_overwrite_core #(
	parameter int MAX_SLOTS = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire rfo_pkg::cmd_t                   cmd,
	output logic                                 done,
	output rfo_pkg::result_t                     result,
	input  wire logic                            cfg_we,
	input  wire logic [rfo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rfo_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

	import rfo_pkg::*;

	localparam int LOG_MAX = $clog2(MAX_SLOTS);
	localparam int AW      = LOG_MAX;
	localparam int PW      = LOG_MAX + 1;
	localparam int CW      = (PW > 6) ? PW : 6;

	logic [2:0]    slots_log2_q;
	logic          overwrite_q;
	logic [PW-1:0] wp_q, rp_q;

	logic             run_active_q;
	logic [AW-1:0]    run_addr_q;
	logic [RUN_W-1:0] run_left_q;

	logic valid_s1;
	beat_t beat_s1;

	logic [2:0]    eff_log2;
	logic [PW-1:0] slots;
	logic [AW-1:0] addr_mask;
	logic [PW-1:0] raw, held;
	logic          full;
	logic          accept;

	logic [PW-1:0] wp_n, rp_n;
	logic          op_we, op_rd, op_ok, run_go;
	logic [AW-1:0] op_addr;
	logic [PW-1:0] raw_n, held_n;

	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	beat_t                beat;

	assign eff_log2  = (slots_log2_q > 3'(LOG_MAX)) ? 3'(LOG_MAX) : slots_log2_q;
	assign slots     = PW'(1) << eff_log2;
	assign addr_mask = AW'(slots - PW'(1));
	assign raw       = wp_q - rp_q;
	assign held      = (raw < slots) ? raw : slots;
	assign full      = (raw >= slots);

	assign busy   = run_active_q;
	assign accept = start && !run_active_q;

	always_comb begin
		wp_n    = wp_q;
		rp_n    = rp_q;
		op_we   = 1'b0;
		op_rd   = 1'b0;
		op_ok   = 1'b0;
		run_go  = 1'b0;
		op_addr = rp_q[AW-1:0];
		case (cmd.opcode)
			OP_PUT: begin
				if (full && overwrite_q) begin
					rp_n = rp_q + PW'(1);
				end
				if (!full || overwrite_q) begin
					op_we = 1'b1;
					wp_n  = wp_q + PW'(1);
					op_ok = 1'b1;
				end
			end
			OP_POP: begin
				if (held != '0) begin
					op_rd = 1'b1;
					rp_n  = rp_q + PW'(1);
					op_ok = 1'b1;
				end
			end
			OP_PEEK: begin
				if (CW'(cmd.slot_offset) < CW'(held)) begin
					op_rd   = 1'b1;
					op_addr = rp_q[AW-1:0] + AW'(cmd.slot_offset);
					op_ok   = 1'b1;
				end
			end
			OP_NEWEST: begin
				if (held != '0) begin
					op_rd   = 1'b1;
					op_addr = wp_q[AW-1:0] - AW'(1);
					op_ok   = 1'b1;
				end
			end
			OP_RUN: begin
				if (cmd.run_length != '0 &&
				    CW'(cmd.slot_offset) + CW'(cmd.run_length) <= CW'(held)) begin
					op_rd   = 1'b1;
					op_addr = rp_q[AW-1:0] + AW'(cmd.slot_offset);
					op_ok   = 1'b1;
					run_go  = 1'b1;
				end
			end
			OP_CLEAR: begin
				wp_n  = '0;
				rp_n  = '0;
				op_ok = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// status after the operation; unchanged during the beats of a run
	assign raw_n  = (accept ? wp_n : wp_q) - (accept ? rp_n : rp_q);
	assign held_n = (raw_n < slots) ? raw_n : slots;

	always_comb begin
		if (run_active_q) begin
			ram_re    = 1'b1;
			ram_raddr = run_addr_q & addr_mask;
			beat.ok       = 1'b1;
			beat.has_word = 1'b1;
			beat.last     = (run_left_q == RUN_W'(1));
		end else begin
			ram_re    = accept && op_rd;
			ram_raddr = op_addr & addr_mask;
			beat.ok       = op_ok;
			beat.has_word = op_rd;
			beat.last     = !run_go || (cmd.run_length == RUN_W'(1));
		end
		beat.held  = HELD_W'(held_n);
		beat.full  = (raw_n >= slots);
		beat.empty = (held_n == '0);
	end

	rfo_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAX_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (accept && op_we),
		.waddr (wp_q[AW-1:0] & addr_mask),
		.wdata (WORD_BITS'(cmd.item_value)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_log2_q <= 3'd4;
			overwrite_q  <= 1'b0;
			wp_q         <= '0;
			rp_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOTS_LOG2: begin
					slots_log2_q <= cfg_wdata;
					wp_q         <= '0;
					rp_q         <= '0;
				end
				REG_OVERWRITE: begin
					overwrite_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			wp_q <= wp_n;
			rp_q <= rp_n;
		end
	end

	// run sequencer: one store read per cycle until the last beat is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q <= 1'b0;
			run_left_q   <= '0;
			run_addr_q   <= '0;
		end else if (run_active_q) begin
			run_active_q <= (run_left_q != RUN_W'(1));
			run_left_q   <= run_left_q - RUN_W'(1);
			run_addr_q   <= run_addr_q + AW'(1);
		end else if (accept && run_go) begin
			run_active_q <= (cmd.run_length != RUN_W'(1));
			run_left_q   <= cmd.run_length - RUN_W'(1);
			run_addr_q   <= op_addr + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept || run_active_q;
			done     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= beat;
		result.read_word   <= (beat_s1.ok && beat_s1.has_word) ? WORD_W'(ram_rdata) : '0;
		result.succeeded   <= beat_s1.ok;
		result.last_of_run <= beat_s1.last;
		result.items_held  <= beat_s1.held;
		result.is_full     <= beat_s1.full;
		result.is_empty    <= beat_s1.empty;
	end

endmodule

`default_nettype wire

FILE: rtl/core/rfo_checker.sv
`default_nettype none

module rfo_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire rfo_pkg::cmd_t                 cmd,
	input wire logic                          done,
	input wire rfo_pkg::result_t              result
);

	import rfo_pkg::*;

	// every accepted command produces a beat, registered through valid_s1 and then done
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted command gave no result beat");

	// busy only rises from an accepted run
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(cmd.opcode) == OP_RUN)
		else $error("busy raised without a run command");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.succeeded) |-> result.read_word == '0)
		else $error("failed beat carries a word");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |-> result.items_held == '0)
		else $error("empty flag with items held");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_full && result.is_empty))
		else $error("ring reported full and empty at once");

endmodule

bind ring_fifo_with_overwrite_core rfo_checker u_rfo_checker (.*);

`default_nettype wire

FILE: sim/tb_ring_fifo_with_overwrite_core.sv
`default_nettype none

module tb_ring_fifo_with_overwrite_core;
	import rfo_pkg::*;

	localparam int MAX_SLOTS = 16;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 50;
	localparam int QUIET_PHASES = 2;
	localparam int PRINT_CAP = 40;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	// ring predictor state
	logic [WORD_W-1:0] ring_words [MAX_SLOTS];
	logic [4:0] head_ptr;
	logic [4:0] tail_ptr;
	logic [2:0] ring_log2;
	logic ring_overwrite;

	result_t expected_beats [$];
	result_t want_beat;
	bit idle_gaps;
	int mismatches;
	int beats_checked;
	int commands_sent;
	int reg_writes;

	ring_fifo_with_overwrite_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int ring_slots();
		return (ring_log2 > 3'd4) ? MAX_SLOTS : (1 << ring_log2);
	endfunction

	function automatic int ring_count();
		logic [4:0] diff;
		diff = head_ptr - tail_ptr;
		return int'(diff);
	endfunction

	function automatic int ring_held();
		return (ring_count() < ring_slots()) ? ring_count() : ring_slots();
	endfunction

	function automatic logic [WORD_W-1:0] ring_read(input int ptr);
		return ring_words[ptr & (ring_slots() - 1)];
	endfunction

	task automatic push_beat(input logic [WORD_W-1:0] word, input bit ok, input bit last);
		result_t r;
		r.read_word = ok ? word : '0;
		r.succeeded = ok;
		r.last_of_run = last;
		r.items_held = HELD_W'(ring_held());
		r.is_full = ring_count() >= ring_slots();
		r.is_empty = ring_held() == 0;
		expected_beats.push_back(r);
	endtask

	task automatic predict_ring(input cmd_t c);
		int n;
		int i;
		int len;
		bit full;
		bit ok;
		bit run_done;
		logic [WORD_W-1:0] word;
		n = ring_slots();
		full = ring_count() >= n;
		ok = 1'b0;
		run_done = 1'b0;
		word = '0;
		len = int'(c.run_length);
		case (c.opcode)
			OP_PUT: begin
				// a full ring with overwrite on drops its oldest word first
				if (full && ring_overwrite)
					tail_ptr = tail_ptr + 5'd1;
				if (!full || ring_overwrite) begin
					ring_words[int'(head_ptr) & (n - 1)] = c.item_value;
					head_ptr = head_ptr + 5'd1;
					ok = 1'b1;
				end
			end
			OP_POP: begin
				if (ring_held() != 0) begin
					word = ring_read(int'(tail_ptr));
					tail_ptr = tail_ptr + 5'd1;
					ok = 1'b1;
				end
			end
			OP_PEEK: begin
				if (int'(c.slot_offset) < ring_held()) begin
					word = ring_read(int'(tail_ptr) + int'(c.slot_offset));
					ok = 1'b1;
				end
			end
			OP_NEWEST: begin
				if (ring_held() != 0) begin
					word = ring_read(int'(head_ptr) - 1);
					ok = 1'b1;
				end
			end
			OP_RUN: begin
				if (len != 0 && int'(c.slot_offset) + len <= ring_held() && len <= MAX_SLOTS) begin
					for (i = 0; i < len; i++)
						push_beat(ring_read(int'(tail_ptr) + int'(c.slot_offset) + i), 1'b1,
							i + 1 == len);
					run_done = 1'b1;
				end
			end
			OP_CLEAR: begin
				head_ptr = '0;
				tail_ptr = '0;
				ok = 1'b1;
			end
			default: ;
		endcase
		if (!run_done)
			push_beat(word, ok, 1'b1);
	endtask

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic [WORD_W-1:0] value,
			input logic [OFFSET_W-1:0] offset, input logic [RUN_W-1:0] len);
		cmd_t c;
		c.opcode = op;
		c.item_value = value;
		c.slot_offset = offset;
		c.run_length = len;
		return c;
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int pick;
		int hld;
		int len;
		hld = ring_held();
		pick = $urandom_range(0, 15);
		c.item_value = (pick == 0) ? '0 : (pick == 1) ? '1 : WORD_W'($urandom);
		c.slot_offset = OFFSET_W'($urandom);
		c.run_length = RUN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			c.opcode = OP_PUT;
		end else if (pick < 55) begin
			c.opcode = OP_POP;
		end else if (pick < 67) begin
			c.opcode = OP_PEEK;
			if (hld > 0 && $urandom_range(0, 3) != 0)
				c.slot_offset = OFFSET_W'($urandom_range(0, hld - 1));
		end else if (pick < 75) begin
			c.opcode = OP_NEWEST;
		end else if (pick < 93) begin
			c.opcode = OP_RUN;
			// mostly runs that fit inside the held words
			if (hld > 0 && $urandom_range(0, 3) != 0) begin
				len = $urandom_range(1, hld);
				c.run_length = RUN_W'(len);
				c.slot_offset = OFFSET_W'($urandom_range(0, hld - len));
			end
		end else if (pick < 97) begin
			c.opcode = OP_CLEAR;
		end else begin
			c.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
		end
		return c;
	endfunction

	// hold start and cmd until the command is taken, then predict its beats
	task automatic drive_command(input cmd_t c);
		if (idle_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		predict_ring(c);
		commands_sent++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		start <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SLOTS_LOG2) begin
			ring_log2 = data;
			head_ptr = '0;
			tail_ptr = '0;
		end else begin
			ring_overwrite = data[0];
		end
		reg_writes++;
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want_beat = expected_beats.pop_front();
				compare_field("read_word", result.read_word, want_beat.read_word);
				compare_field("succeeded", WORD_W'(result.succeeded), WORD_W'(want_beat.succeeded));
				compare_field("last_of_run", WORD_W'(result.last_of_run),
					WORD_W'(want_beat.last_of_run));
				compare_field("items_held", WORD_W'(result.items_held),
					WORD_W'(want_beat.items_held));
				compare_field("is_full", WORD_W'(result.is_full), WORD_W'(want_beat.is_full));
				compare_field("is_empty", WORD_W'(result.is_empty), WORD_W'(want_beat.is_empty));
				beats_checked++;
			end
		end
	end

	task automatic test_empty_ring();
		drive_command(make_cmd(OP_POP, '0, '0, 5'd1));
		drive_command(make_cmd(OP_NEWEST, '0, '0, 5'd1));
		drive_command(make_cmd(OP_PEEK, '0, 4'd0, 5'd1));
		drive_command(make_cmd(OP_RUN, '0, 4'd0, 5'd1));
		drive_command(make_cmd(OP_SPARE_A, '1, 4'hf, 5'h1f));
		drive_command(make_cmd(OP_SPARE_B, '0, '0, '0));
		drive_command(make_cmd(OP_CLEAR, '1, '0, '0));
	endtask

	task automatic test_put_and_read();
		drive_command(make_cmd(OP_PUT, '0, '0, '0));
		drive_command(make_cmd(OP_PUT, '1, 4'hf, 5'h1f));
		drive_command(make_cmd(OP_PUT, 32'hA5A5_5A5A, '0, '0));
		drive_command(make_cmd(OP_PEEK, '0, 4'd2, '0));
		drive_command(make_cmd(OP_PEEK, '0, 4'd15, '0));
		drive_command(make_cmd(OP_NEWEST, '0, '0, '0));
		drive_command(make_cmd(OP_RUN, '0, 4'd1, 5'd2));
		drive_command(make_cmd(OP_RUN, '0, 4'd0, 5'd0));
		drive_command(make_cmd(OP_RUN, '0, 4'd0, 5'd31));
		drive_command(make_cmd(OP_POP, '0, '0, '0));
	endtask

	task automatic test_overflow();
		write_register(REG_SLOTS_LOG2, 3'd1);
		drive_command(make_cmd(OP_PUT, 32'h1111_1111, '0, '0));
		drive_command(make_cmd(OP_PUT, 32'h2222_2222, '0, '0));
		drive_command(make_cmd(OP_PUT, 32'h3333_3333, '0, '0));
		write_register(REG_OVERWRITE, 3'b111);
		drive_command(make_cmd(OP_PUT, 32'h4444_4444, '0, '0));
		drive_command(make_cmd(OP_PUT, 32'h5555_5555, '0, '0));
		drive_command(make_cmd(OP_RUN, '0, 4'd0, 5'd2));
		drive_command(make_cmd(OP_NEWEST, '0, '0, '0));
		drive_command(make_cmd(OP_POP, '0, '0, '0));
	endtask

	task automatic test_random_phases();
		logic [2:0] sizes [PHASES];
		int p;
		int k;
		sizes = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd1, 3'd5, 3'd6, 3'd4, 3'd2};
		for (p = 0; p < PHASES; p++) begin
			write_register(REG_SLOTS_LOG2, sizes[p]);
			write_register(REG_OVERWRITE, {(CFG_DAT_W-1)'($urandom), p[0]});
			idle_gaps = p < PHASES - QUIET_PHASES;
			for (k = 0; k < PHASE_ITEMS; k++)
				drive_command(random_command());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		ring_log2 = 3'd4;
		ring_overwrite = 1'b0;
		head_ptr = '0;
		tail_ptr = '0;
		idle_gaps = 1'b1;
		mismatches = 0;
		beats_checked = 0;
		commands_sent = 0;
		reg_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_put_and_read();
		test_overflow();
		test_random_phases();

		start <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d commands, checked %0d result beats, %0d register writes.",
			commands_sent, beats_checked, reg_writes);
		$display("Ring sizes 1 to 16 with saturation, overwrite on and off, all opcodes.");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d beats outstanding.", expected_beats.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
